FILE: sv/arp_reply_frame_filter_defines.svh
// ----------------------------------------------------------------------------
// ARP reply frame filter assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ARP_REPLY_FRAME_FILTER_DEFINES_SVH
`define ARP_REPLY_FRAME_FILTER_DEFINES_SVH

// same-cycle implication
`define ARF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/arf_pkg.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter package
// Shared types, constants and byte classification helpers.
// ----------------------------------------------------------------------------
package arf_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned IpW      = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned MinBytes = 42;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [PosW-1:0] PosSat  = PosW'(MinBytes);
  localparam logic [PosW-1:0] PosLast = PosW'(MinBytes - 1);

  localparam logic [7:0] EtypeHi = 8'h08;
  localparam logic [7:0] EtypeLo = 8'h06;
  localparam logic [7:0] OpcHi   = 8'h00;
  localparam logic [7:0] OpcLo   = 8'h02;

  // role of a frame byte
  typedef enum logic [3:0] {
    KIND_NONE  = 4'd0,
    KIND_DST   = 4'd1,
    KIND_SRC   = 4'd2,
    KIND_ET_HI = 4'd3,
    KIND_ET_LO = 4'd4,
    KIND_OP_HI = 4'd5,
    KIND_OP_LO = 4'd6,
    KIND_SMAC  = 4'd7,
    KIND_SIP   = 4'd8,
    KIND_TMAC  = 4'd9
  } arf_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    arf_kind_e  kind;
    logic       mismatch;
    logic       full_len;
  } arf_entry_t;

  function automatic arf_kind_e classify(input logic [PosW-1:0] pos);
    arf_kind_e k;
    k = KIND_NONE;
    case (pos) inside
      [6'd0 : 6'd5]:   k = KIND_DST;
      [6'd6 : 6'd11]:  k = KIND_SRC;
      6'd12:           k = KIND_ET_HI;
      6'd13:           k = KIND_ET_LO;
      6'd20:           k = KIND_OP_HI;
      6'd21:           k = KIND_OP_LO;
      [6'd22 : 6'd27]: k = KIND_SMAC;
      [6'd28 : 6'd31]: k = KIND_SIP;
      [6'd32 : 6'd37]: k = KIND_TMAC;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] mac_byte(input logic [MacW-1:0] mac,
                                          input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/arf_if.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter channels
// Valid/ready channels for frame bytes in and filter results out.
// ----------------------------------------------------------------------------
interface arf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface arf_result_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [arf_pkg::IpW-1:0]     sender_ip;
  logic [arf_pkg::MacW-1:0]    sender_mac;

  modport source (output valid, accepted, sender_ip, sender_mac, input ready);
  modport sink   (input valid, accepted, sender_ip, sender_mac, output ready);
endinterface

FILE: sv/arf_front.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter front end
// Tracks byte position, classifies each beat, compares to own MAC/ARP fields.
// ----------------------------------------------------------------------------
module arf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [arf_pkg::MacW-1:0]  own_mac_i,
  arf_byte_if.sink                  rx,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output arf_pkg::arf_entry_t       q_entry_o
);

  logic [arf_pkg::PosW-1:0] pos_q, pos_d;
  logic [arf_pkg::PosW-1:0] off;
  logic [7:0]               expect_byte;
  arf_pkg::arf_kind_e       kind;

  assign rx.ready = !q_full_i;
  assign q_push_o = rx.valid && !q_full_i;

  assign kind = arf_pkg::classify(pos_q);

  always_comb begin
    off         = '0;
    expect_byte = 8'h00;
    case (kind)
      arf_pkg::KIND_DST:   off = pos_q;
      arf_pkg::KIND_SRC:   off = pos_q - arf_pkg::PosW'(6);
      arf_pkg::KIND_SMAC:  off = pos_q - arf_pkg::PosW'(22);
      arf_pkg::KIND_TMAC:  off = pos_q - arf_pkg::PosW'(32);
      default:             off = '0;
    endcase
    case (kind)
      arf_pkg::KIND_ET_HI: expect_byte = arf_pkg::EtypeHi;
      arf_pkg::KIND_ET_LO: expect_byte = arf_pkg::EtypeLo;
      arf_pkg::KIND_OP_HI: expect_byte = arf_pkg::OpcHi;
      arf_pkg::KIND_OP_LO: expect_byte = arf_pkg::OpcLo;
      default:             expect_byte = arf_pkg::mac_byte(own_mac_i, off[2:0]);
    endcase
  end

  always_comb begin
    q_entry_o.data     = rx.frame_byte;
    q_entry_o.last     = rx.frame_end;
    q_entry_o.kind     = kind;
    q_entry_o.mismatch = rx.frame_byte != expect_byte;
    q_entry_o.full_len = pos_q >= arf_pkg::PosLast;
  end

  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      if (rx.frame_end) begin
        pos_d = '0;
      end else if (pos_q < arf_pkg::PosSat) begin
        pos_d = pos_q + arf_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: sv/arf_queue.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter beat queue
// Small flop-based FIFO between the classifier and the check/capture stage.
// ----------------------------------------------------------------------------
module arf_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  arf_pkg::arf_entry_t          entry_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic                         valid_o,
  output arf_pkg::arf_entry_t          entry_o,
  output logic [arf_pkg::QCntW-1:0]    count_o
);

  arf_pkg::arf_entry_t         mem_q [arf_pkg::QDepth];
  logic [arf_pkg::QAw-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [arf_pkg::QCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == arf_pkg::QCntW'(arf_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = push_i ? wr_q + arf_pkg::QAw'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + arf_pkg::QAw'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + arf_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - arf_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/arf_back.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter back end
// Folds per-beat checks into frame flags, captures sender fields, emits result.
// ----------------------------------------------------------------------------
module arf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  arf_pkg::arf_entry_t   q_entry_i,
  output logic                  q_pop_o,
  arf_result_if.source          res
);

  logic                     pass_q, pass_d;
  logic                     src_diff_q, src_diff_d;
  logic                     snd_diff_q, snd_diff_d;
  logic [arf_pkg::MacW-1:0] mac_q, mac_d;
  logic [arf_pkg::IpW-1:0]  ip_q, ip_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_acc_q;
  logic [arf_pkg::MacW-1:0] out_mac_q;
  logic [arf_pkg::IpW-1:0]  out_ip_q;
  logic                     ok;

  // a last beat needs a free output slot; other beats always drain
  assign q_pop_o = q_valid_i && (!q_entry_i.last || !out_valid_q || res.ready);

  always_comb begin
    pass_d     = pass_q;
    src_diff_d = src_diff_q;
    snd_diff_d = snd_diff_q;
    mac_d      = mac_q;
    ip_d       = ip_q;
    case (q_entry_i.kind)
      arf_pkg::KIND_DST, arf_pkg::KIND_TMAC, arf_pkg::KIND_ET_HI,
      arf_pkg::KIND_ET_LO, arf_pkg::KIND_OP_HI, arf_pkg::KIND_OP_LO: begin
        pass_d = pass_q && !q_entry_i.mismatch;
      end
      arf_pkg::KIND_SRC: begin
        src_diff_d = src_diff_q || q_entry_i.mismatch;
      end
      arf_pkg::KIND_SMAC: begin
        snd_diff_d = snd_diff_q || q_entry_i.mismatch;
        mac_d      = {mac_q[arf_pkg::MacW-9:0], q_entry_i.data};
      end
      arf_pkg::KIND_SIP: begin
        ip_d = {ip_q[arf_pkg::IpW-9:0], q_entry_i.data};
      end
      default: begin
      end
    endcase
  end

  assign ok = q_entry_i.full_len && pass_d && src_diff_d && snd_diff_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o && q_entry_i.last) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= 1'b1;
      src_diff_q  <= 1'b0;
      snd_diff_q  <= 1'b0;
      mac_q       <= '0;
      ip_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        if (q_entry_i.last) begin
          pass_q     <= 1'b1;
          src_diff_q <= 1'b0;
          snd_diff_q <= 1'b0;
          mac_q      <= '0;
          ip_q       <= '0;
        end else begin
          pass_q     <= pass_d;
          src_diff_q <= src_diff_d;
          snd_diff_q <= snd_diff_d;
          mac_q      <= mac_d;
          ip_q       <= ip_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.last) begin
      out_acc_q <= ok;
      out_mac_q <= ok ? mac_d : '0;
      out_ip_q  <= ok ? ip_d : '0;
    end
  end

  assign res.valid      = out_valid_q;
  assign res.accepted   = out_acc_q;
  assign res.sender_ip  = out_ip_q;
  assign res.sender_mac = out_mac_q;

endmodule

FILE: sv/arp_reply_frame_filter.sv
// ----------------------------------------------------------------------------
// ARP reply frame filter
// Checks received Ethernet frames for ARP replies addressed to this station.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one frame byte per beat (frame_byte) with frame_end on the
//   final byte. res_o carries one result per frame: accepted, plus sender_ip
//   and sender_mac (zero when rejected). cfg_we_i/cfg_wdata_i load own_mac.
//   Throughput: one beat per cycle while the queue is not full. Each beat
//   is classified and compared in the front end, then queued (4 entries)
//   for the check and capture stage, which retires one beat per cycle
//   unless a last beat waits for a free output register. Result path: the
//   last beat passes through the queue, then the output register; queued
//   beats ahead of it and a held res_o delay the result further.
//   Stall: if res_o is held, the last beat of the next frame waits at the
//   queue head; earlier beats keep draining and rx_i stalls only once the
//   queue is full.
//   Reset: own_mac clears to zero, position and frame flags return to the
//   start of a frame, queue and output register empty.
// ----------------------------------------------------------------------------
`include "arp_reply_frame_filter_defines.svh"

module arp_reply_frame_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [arf_pkg::MacW-1:0]  cfg_wdata_i,
  arf_byte_if.sink                  rx_i,
  arf_result_if.source              res_o
);

  logic [arf_pkg::MacW-1:0]  own_mac_q, own_mac_d;
  logic                      q_push, q_full, q_pop, q_valid;
  arf_pkg::arf_entry_t       q_in, q_out;
  logic [arf_pkg::QCntW-1:0] q_cnt;
  logic                      res_rej;
  logic                      res_zero;

  assign own_mac_d = cfg_we_i ? cfg_wdata_i : own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
    end else begin
      own_mac_q <= own_mac_d;
    end
  end

  arf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .own_mac_i (own_mac_q),
    .rx        (rx_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  arf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out),
    .count_o (q_cnt)
  );

  arf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .res       (res_o)
  );

  assign res_rej  = res_o.valid && !res_o.accepted;
  assign res_zero = (res_o.sender_ip == '0) && (res_o.sender_mac == '0);

  `ARF_ASSERT_NOW(a_q_cnt_bound, 1'b1, q_cnt <= arf_pkg::QCntW'(arf_pkg::QDepth), "queue overflow")
  `ARF_ASSERT_NOW(a_reject_zero, res_rej, res_zero, "rejected result carries data")
  `ARF_ASSERT_NEXT(a_last_to_out, q_pop && q_out.last, res_o.valid, "frame end gave no result")
  `ARF_ASSERT_NOW(a_pop_needs_data, q_pop, q_valid, "pop from empty queue")

endmodule
